[rtl/core/assert_macros.svh]
// Assertion helpers clocked on clk, quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define PST_ASSERT_NEXT(lbl, pre, post, msg) \
	`PST_ASSERT(lbl, (pre) |=> (post), msg)

`endif

[rtl/core/pst_pkg.sv]
`default_nettype none
package pst_pkg;
	localparam int MAX_SEGS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_OUT_W     = 4;
	localparam int TERM_W        = 41;
	localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, 40'b0};

	typedef enum logic [1:0] {OP_CLEAR, OP_ADD, OP_REWIND, OP_EVAL} op_t;
	typedef enum logic [1:0] {ST_OK, ST_FULL, ST_DIVZ, ST_EMPTY} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FULL_RD, S_FULL_DATA, S_DIV1, S_DIV1_W, S_DIV2, S_DIV2_W,
		S_EV_RD, S_EV_CMP, S_MUL_SQ, S_MUL_VEL, S_MUL_ALO, S_MUL_AHI, S_SUM, S_OUT
	} state_t;

	typedef struct packed {
		logic signed [31:0] end_time;
		logic signed [31:0] end_pos;
		logic signed [31:0] end_vel;
		logic signed [31:0] accel;
	} seg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction
endpackage
`default_nettype wire

[rtl/core/pst_mem.sv]
`default_nettype none
module pst_mem import pst_pkg::*; #(
	parameter int DEPTH = MAX_SEGS_DEF,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire seg_t          wdata,
	input  wire logic [AW-1:0] raddr,
	output seg_t               rdata
);
	seg_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/pst_div.sv]
`default_nettype none
module pst_div import pst_pkg::*; #(
	parameter int NW = 50
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [32:0]   den,
	output logic      [NW-1:0] quo,
	output div_stat_t          stat
);
	localparam int CNTW = $clog2(NW + 1);

	logic [32:0]     rem_q;
	logic [NW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [33:0]     shifted;
	logic            fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den};
	assign quo     = quo_q;
	assign stat    = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? 33'(shifted - {1'b0, den}) : shifted[32:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end
endmodule
`default_nettype wire

[rtl/core/parabolic_segment_trajectory_top.sv]
// Segment table for one axis of a parabolic-blend trajectory, Q(FRAC_BITS) fixed point. Segments
// live in one synchronous memory of MAX_SEGS entries; one request is handled at a time and the
// result sits in an output register, so the next request is taken while a result waits. An add
// runs up to two restoring divisions, one quotient bit per cycle. An evaluation does a memory
// read then a compare for each table entry the cursor passes, then, unless the query lies past
// the last segment, a sequence of products on the shared 32x32 multiplier. Reads of slots never
// written give undefined data.
`default_nettype none
module parabolic_segment_trajectory_top import pst_pkg::*; #(
	parameter int MAX_SEGS  = MAX_SEGS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [30:0]        start_time,
	input  wire logic signed [31:0] start_pos,
	input  wire logic signed [31:0] end_pos,
	input  wire logic signed [31:0] start_vel,
	input  wire logic signed [31:0] end_vel,
	input  wire logic [30:0]        query_time,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      value,
	output logic [1:0]              status,
	output logic [IDX_OUT_W-1:0]    segment_index
);
	localparam int IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
	localparam int CW = $clog2(MAX_SEGS + 1);
	localparam int NW = 34 + FRAC_BITS;

	state_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic [IW-1:0]        cursor_q;
	logic [30:0]          t_q;
	logic [30:0]          t0_q;
	logic signed [32:0]   diff_q;
	logic signed [32:0]   dv_q;
	logic signed [31:0]   sf_q;
	logic signed [31:0]   vf_q;
	logic [32:0]          den_q;
	logic                 neg_q;
	logic signed [31:0]   dur_q;
	logic signed [31:0]   res_value_q;
	status_t              res_status_q;
	logic [IW-1:0]        res_index_q;
	logic [31:0]          dm_q;
	logic [63:0]          d2_q;
	logic signed [41:0]   t1_q;
	logic [63:0]          plo_q;
	logic [63:0]          prod_q;

	logic                 div_start;
	logic [NW-1:0]        div_num;
	logic [32:0]          div_den;
	logic [NW-1:0]        div_quo;
	div_stat_t            div_stat;

	logic                 mem_we;
	logic [IW-1:0]        mem_raddr;
	seg_t                 mem_wdata;
	seg_t                 rdata;

	logic                 accept;
	op_t                  op_in;
	logic signed [32:0]   den_sum;
	logic signed [31:0]   q_sat;
	logic signed [32:0]   endt_sum;
	logic signed [31:0]   endt;
	logic                 later;
	logic                 adv;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          sh1;
	logic [TERM_W-1:0]    m1;
	logic [95:0]          big;
	logic [63:0]          sh2;
	logic [TERM_W-1:0]    m2;
	logic signed [41:0]   t2;
	logic signed [42:0]   vsum;
	logic signed [31:0]   vsat;
	logic                 out_free;
	logic [IW+IDX_OUT_W-1:0] idx_wide;

	assign accept  = in_valid && in_ready;
	assign op_in   = op_t'(op);
	assign den_sum = 33'(start_vel) + 33'(end_vel);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		if (neg_q) begin
			if (div_quo[NW-1:32] != '0 || (div_quo[31] && div_quo[30:0] != '0)) begin
				q_sat = 32'sh8000_0000;
			end else begin
				q_sat = 32'(~div_quo[31:0] + 32'd1);
			end
		end else begin
			q_sat = (div_quo[NW-1:31] != '0) ? 32'sh7FFF_FFFF : 32'(div_quo[31:0]);
		end
	end

	assign endt_sum = $signed({2'b00, t0_q}) + 33'(dur_q);
	assign endt = (endt_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(endt_sum < -33'sh0_8000_0000) ? 32'sh8000_0000 : endt_sum[31:0];

	assign later = $signed({1'b0, t_q}) > rdata.end_time;
	assign adv = later && ((CW+1)'(cursor_q) + 1'b1 < (CW+1)'(count_q));

	pst_div #(.NW(NW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.stat  (div_stat)
	);

	always_comb begin
		if (state_q == S_DIV1 || state_q == S_DIV1_W) begin
			div_num = NW'(diff_q[32] ? 33'(-diff_q) : 33'(diff_q)) << (FRAC_BITS + 1);
			div_den = den_q;
		end else begin
			div_num = NW'(dv_q[32] ? 33'(-dv_q) : 33'(dv_q)) << FRAC_BITS;
			div_den = {1'b0, abs32(dur_q)};
		end
	end

	assign mem_wdata = '{end_time: endt, end_pos: sf_q, end_vel: vf_q, accel: q_sat};

	pst_mem #(.DEPTH(MAX_SEGS), .AW(IW)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(IW'(count_q)),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = cursor_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op_in)
						OP_CLEAR: state_d = S_OUT;
						OP_ADD: begin
							if (count_q == CW'(MAX_SEGS)) begin
								state_d = S_FULL_RD;
							end else if (den_sum == '0) begin
								state_d = S_OUT;
							end else begin
								state_d = S_DIV1;
							end
						end
						OP_REWIND, OP_EVAL: state_d = (count_q == '0) ? S_OUT : S_EV_RD;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_FULL_RD: begin
				mem_raddr = IW'(MAX_SEGS - 1);
				state_d = S_FULL_DATA;
			end
			S_FULL_DATA: state_d = S_OUT;
			S_DIV1: begin
				div_start = 1'b1;
				state_d = S_DIV1_W;
			end
			S_DIV1_W: begin
				if (div_stat.done) begin
					state_d = (q_sat == '0) ? S_OUT : S_DIV2;
				end
			end
			S_DIV2: begin
				div_start = 1'b1;
				state_d = S_DIV2_W;
			end
			S_DIV2_W: begin
				if (div_stat.done) begin
					mem_we = 1'b1;
					state_d = S_OUT;
				end
			end
			S_EV_RD: state_d = S_EV_CMP;
			S_EV_CMP: begin
				if (adv) begin
					state_d = S_EV_RD;
				end else if (later) begin
					state_d = S_OUT;
				end else begin
					state_d = S_MUL_SQ;
				end
			end
			S_MUL_SQ: state_d = S_MUL_VEL;
			S_MUL_VEL: state_d = S_MUL_ALO;
			S_MUL_ALO: state_d = S_MUL_AHI;
			S_MUL_AHI: state_d = S_SUM;
			S_SUM: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			S_MUL_SQ: begin
				mul_a = dm_q;
				mul_b = dm_q;
			end
			S_MUL_VEL: begin
				mul_a = abs32(rdata.end_vel);
				mul_b = dm_q;
			end
			S_MUL_ALO: begin
				mul_a = abs32(rdata.accel);
				mul_b = d2_q[31:0];
			end
			default: begin
				mul_a = abs32(rdata.accel);
				mul_b = d2_q[63:32];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign sh1 = prod_q >> FRAC_BITS;
	assign m1  = (sh1 > 64'(TERM_CAP)) ? TERM_CAP : sh1[TERM_W-1:0];
	assign big = {32'b0, plo_q} + {prod_q, 32'b0};
	assign sh2 = big[63:0] >> (FRAC_BITS + 1);
	assign m2  = (big[95:64] != '0 || sh2 > 64'(TERM_CAP)) ? TERM_CAP : sh2[TERM_W-1:0];
	assign t2  = rdata.accel[31] ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
	assign vsum = 43'(rdata.end_pos) + 43'(t1_q) + 43'(t2);
	assign vsat = (vsum > 43'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(vsum < -43'sh8000_0000) ? 32'sh8000_0000 : vsum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			if (accept) begin
				unique case (op_in)
					OP_CLEAR: begin
						count_q  <= '0;
						cursor_q <= '0;
					end
					OP_REWIND: cursor_q <= '0;
					OP_EVAL: begin
						if (count_q != '0 && (CW+1)'(cursor_q) >= (CW+1)'(count_q)) begin
							cursor_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == S_EV_CMP && adv) begin
				cursor_q <= cursor_q + 1'b1;
			end
			if (mem_we) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t0_q   <= start_time;
				t_q    <= (op_in == OP_REWIND) ? '0 : query_time;
				diff_q <= 33'(end_pos) - 33'(start_pos);
				dv_q   <= 33'(end_vel) - 33'(start_vel);
				sf_q   <= end_pos;
				vf_q   <= end_vel;
				den_q  <= den_sum[32] ? 33'(-den_sum) : 33'(den_sum);
				neg_q  <= den_sum[32] ^ (end_pos < start_pos);
				res_value_q <= '0;
				if (op_in == OP_ADD) begin
					res_status_q <= ST_DIVZ;
					res_index_q  <= IW'(count_q);
				end else begin
					res_status_q <= (op_in == OP_CLEAR) ? ST_OK : ST_EMPTY;
					res_index_q  <= '0;
				end
			end
			S_FULL_DATA: begin
				res_value_q  <= rdata.end_time;
				res_status_q <= ST_FULL;
				res_index_q  <= IW'(MAX_SEGS - 1);
			end
			S_DIV1_W: begin
				if (div_stat.done) begin
					dur_q <= q_sat;
					neg_q <= dv_q[32] ^ q_sat[31];
				end
			end
			S_DIV2_W: begin
				if (div_stat.done) begin
					res_value_q  <= endt;
					res_status_q <= ST_OK;
				end
			end
			S_EV_CMP: begin
				dm_q         <= 32'(rdata.end_time - $signed({1'b0, t_q}));
				res_value_q  <= rdata.end_pos;
				res_status_q <= ST_OK;
				res_index_q  <= cursor_q;
			end
			S_MUL_VEL: d2_q <= prod_q >> FRAC_BITS;
			S_MUL_ALO: begin
				t1_q <= (rdata.end_vel[31] ^ (dm_q != '0)) ?
					-$signed({1'b0, m1}) : $signed({1'b0, m1});
			end
			S_MUL_AHI: plo_q <= prod_q;
			S_SUM: res_value_q <= vsat;
			default: ;
		endcase
	end

	assign idx_wide = {{IDX_OUT_W{1'b0}}, res_index_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			value         <= res_value_q;
			status        <= res_status_q;
			segment_index <= idx_wide[IDX_OUT_W-1:0];
		end
	end
endmodule
`default_nettype wire

[rtl/core/pst_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module pst_props import pst_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic signed [31:0] value,
	input wire logic [1:0]        status,
	input wire logic [IDX_OUT_W-1:0] segment_index
);
	`PST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value), "result dropped")
	`PST_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request overlap")
	`PST_ASSERT(a_empty_result, (out_valid && status == ST_EMPTY |-> value == 0 && segment_index == 0), "bad empty result")
	`PST_ASSERT(a_divz_result, (out_valid && status == ST_DIVZ |-> value == 0), "bad divide result")
endmodule

bind parabolic_segment_trajectory_top pst_props u_pst_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.value        (value),
	.status       (status),
	.segment_index(segment_index)
);
`default_nettype wire
